FILE: rtl/core/cdp_pkg.sv
// ----------------------------------------------------------------------------
// cdp_pkg: shared definitions for the positional circular deque
// Command and status codes, default sizes and the command queue entry.
// ----------------------------------------------------------------------------
package cdp_pkg;

  localparam int unsigned DefDepth    = 64;
  localparam int unsigned DefWordBits = 32;

  localparam int unsigned CmdBits   = 3;
  localparam int unsigned PosBits   = 7;
  localparam int unsigned WordBits  = 32;
  localparam int unsigned StatBits  = 2;
  localparam int unsigned CountBits = 7;

  typedef enum logic [CmdBits-1:0] {
    CmdGet       = 3'd0,
    CmdInsert    = 3'd1,
    CmdRemove    = 3'd2,
    CmdPushFront = 3'd3,
    CmdPopFront  = 3'd4,
    CmdPushBack  = 3'd5,
    CmdPopBack   = 3'd6
  } cmd_e;

  typedef enum logic [StatBits-1:0] {
    StatOk    = 2'd0,
    StatOob   = 2'd1,
    StatEmpty = 2'd2,
    StatFull  = 2'd3
  } status_e;

  // One classified command, handed from the front end to the back end.
  typedef struct packed {
    cmd_e                 cmd;
    logic [PosBits-1:0]   pos;
    logic [WordBits-1:0]  word;
    status_e              status;
    logic [CountBits-1:0] count;
  } entry_t;

endpackage

FILE: rtl/core/cdp_ram.sv
// ----------------------------------------------------------------------------
// cdp_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module cdp_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/cdp_cmdq.sv
// ----------------------------------------------------------------------------
// cdp_cmdq: two-entry command queue
// Decouples the classifying front end from the executing back end.
// ----------------------------------------------------------------------------
module cdp_cmdq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  cdp_pkg::entry_t push_entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output cdp_pkg::entry_t pop_entry_o
);

  cdp_pkg::entry_t slot_q [2];
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [1:0]      used_q, used_d;
  logic            do_push, do_pop;

  assign full_o      = used_q[1];
  assign valid_o     = (used_q != 2'd0);
  assign pop_entry_o = slot_q[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    used_d   = used_q;
    if (do_push && !do_pop) begin
      used_d = used_q + 2'd1;
    end else if (do_pop && !do_push) begin
      used_d = used_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      used_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      used_q   <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

FILE: rtl/core/cdp_front.sv
// ----------------------------------------------------------------------------
// cdp_front: command front end
// Tracks the fill count, decides each command's status and resulting count.
// ----------------------------------------------------------------------------
module cdp_front #(
  parameter int unsigned DEPTH = cdp_pkg::DefDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [cdp_pkg::CmdBits-1:0]   command_i,
  input  logic [cdp_pkg::PosBits-1:0]   position_i,
  input  logic [cdp_pkg::WordBits-1:0]  word_in_i,
  output cdp_pkg::entry_t               entry_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned CmpW = (CntW > cdp_pkg::PosBits) ? CntW : cdp_pkg::PosBits;

  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [CmpW-1:0]     pos_x, cnt_x, next_x;
  logic                is_full, is_empty;
  cdp_pkg::status_e    status;

  assign pos_x    = CmpW'(position_i);
  assign cnt_x    = CmpW'(cnt_q);
  assign is_full  = (cnt_q == CntW'(DEPTH));
  assign is_empty = (cnt_q == '0);

  always_comb begin
    status = cdp_pkg::StatOk;
    cnt_d  = cnt_q;
    unique case (cdp_pkg::cmd_e'(command_i))
      cdp_pkg::CmdGet: begin
        if (pos_x >= cnt_x) status = cdp_pkg::StatOob;
      end
      cdp_pkg::CmdInsert: begin
        if (pos_x > cnt_x) status = cdp_pkg::StatOob;
        else if (is_full)  status = cdp_pkg::StatFull;
        else               cnt_d  = cnt_q + CntW'(1);
      end
      cdp_pkg::CmdRemove: begin
        if (pos_x >= cnt_x) status = cdp_pkg::StatOob;
        else                cnt_d  = cnt_q - CntW'(1);
      end
      cdp_pkg::CmdPushFront, cdp_pkg::CmdPushBack: begin
        if (is_full) status = cdp_pkg::StatFull;
        else         cnt_d  = cnt_q + CntW'(1);
      end
      cdp_pkg::CmdPopFront, cdp_pkg::CmdPopBack: begin
        if (is_empty) status = cdp_pkg::StatEmpty;
        else          cnt_d  = cnt_q - CntW'(1);
      end
      default: ;
    endcase
  end

  assign next_x = CmpW'(cnt_d);

  always_comb begin
    entry_o.cmd    = cdp_pkg::cmd_e'(command_i);
    entry_o.pos    = position_i;
    entry_o.word   = word_in_i;
    entry_o.status = status;
    entry_o.count  = next_x[cdp_pkg::CountBits-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (accept_i) begin
      cnt_q <= cnt_d;
    end
  end

endmodule

FILE: rtl/core/cdp_back.sv
// ----------------------------------------------------------------------------
// cdp_back: command back end
// Carries out queued commands on the entry RAM and registers the result.
// ----------------------------------------------------------------------------
module cdp_back #(
  parameter int unsigned DEPTH     = cdp_pkg::DefDepth,
  parameter int unsigned WORD_BITS = cdp_pkg::DefWordBits
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           q_valid_i,
  input  cdp_pkg::entry_t                q_entry_i,
  output logic                           q_pop_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [cdp_pkg::WordBits-1:0]   word_out_o,
  output logic [cdp_pkg::StatBits-1:0]   status_o,
  output logic [cdp_pkg::CountBits-1:0]  count_o
);

  localparam int unsigned PtrW   = $clog2(DEPTH);
  localparam int unsigned CntW   = $clog2(DEPTH + 1);
  localparam int unsigned StoreW = (WORD_BITS < cdp_pkg::WordBits) ? WORD_BITS
                                                                   : cdp_pkg::WordBits;

  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StRemCap,
    StMvRd,
    StMvWr
  } state_e;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  function automatic logic [PtrW-1:0] ptr_dec(input logic [PtrW-1:0] p);
    return (p == '0) ? PtrW'(DEPTH - 1) : p - PtrW'(1);
  endfunction

  state_e                        state_q, state_d;
  logic [PtrW-1:0]               tail_q, tail_d, head_q, head_d;
  logic [CntW-1:0]               cnt_q, cnt_d, moves_q, moves_d;
  logic [PtrW-1:0]               cur_q, cur_d, nb_q, nb_d;
  logic                          is_ins_q, is_ins_d;
  logic [StoreW-1:0]             ent_word_q, ent_word_d, rd_word_q, rd_word_d;
  cdp_pkg::status_e              ent_status_q, ent_status_d;
  logic [cdp_pkg::CountBits-1:0] ent_count_q, ent_count_d;
  logic                          out_valid_q, out_valid_d;
  logic [cdp_pkg::WordBits-1:0]  out_word_q, out_word_d;
  logic [cdp_pkg::StatBits-1:0]  out_status_q, out_status_d;
  logic [cdp_pkg::CountBits-1:0] out_count_q, out_count_d;

  logic                          ram_we;
  logic [PtrW-1:0]               ram_waddr, ram_raddr;
  logic [StoreW-1:0]             ram_wdata, ram_rdata;
  logic [PtrW:0]                 pos_sum;
  logic [PtrW-1:0]               pos_addr, nb;
  logic                          start;

  cdp_ram #(
    .Width (StoreW),
    .Depth (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Physical slot of the logical index, one wrap at most.
  assign pos_sum  = {1'b0, tail_q} + (PtrW + 1)'(q_entry_i.pos);
  assign pos_addr = (pos_sum >= (PtrW + 1)'(DEPTH)) ? PtrW'(pos_sum - (PtrW + 1)'(DEPTH))
                                                    : PtrW'(pos_sum);
  assign nb       = is_ins_q ? ptr_dec(cur_q) : ptr_inc(cur_q);
  assign start    = (state_q == StIdle) && q_valid_i && (!out_valid_q || !out_stall_i);
  assign q_pop_o  = start;

  always_comb begin
    state_d      = state_q;
    tail_d       = tail_q;
    head_d       = head_q;
    cnt_d        = cnt_q;
    moves_d      = moves_q;
    cur_d        = cur_q;
    nb_d         = nb_q;
    is_ins_d     = is_ins_q;
    ent_word_d   = ent_word_q;
    rd_word_d    = rd_word_q;
    ent_status_d = ent_status_q;
    ent_count_d  = ent_count_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_word_d   = out_word_q;
    out_status_d = out_status_q;
    out_count_d  = out_count_q;
    ram_we       = 1'b0;
    ram_waddr    = cur_q;
    ram_wdata    = ent_word_q;
    ram_raddr    = cur_q;

    unique case (state_q)
      StIdle: begin
        if (start) begin
          ent_word_d   = q_entry_i.word[StoreW-1:0];
          ent_status_d = q_entry_i.status;
          ent_count_d  = q_entry_i.count;
          out_word_d   = '0;
          out_status_d = q_entry_i.status;
          out_count_d  = q_entry_i.count;
          if (q_entry_i.status != cdp_pkg::StatOk) begin
            out_valid_d = 1'b1;
          end else begin
            unique case (q_entry_i.cmd)
              cdp_pkg::CmdGet: begin
                ram_raddr = pos_addr;
                state_d   = StRead;
              end
              cdp_pkg::CmdInsert: begin
                cur_d    = head_q;
                moves_d  = cnt_q - CntW'(q_entry_i.pos);
                is_ins_d = 1'b1;
                cnt_d    = cnt_q + CntW'(1);
                state_d  = StMvRd;
              end
              cdp_pkg::CmdRemove: begin
                cur_d     = pos_addr;
                ram_raddr = pos_addr;
                moves_d   = cnt_q - CntW'(q_entry_i.pos) - CntW'(1);
                is_ins_d  = 1'b0;
                cnt_d     = cnt_q - CntW'(1);
                state_d   = StRemCap;
              end
              cdp_pkg::CmdPushFront: begin
                ram_we      = 1'b1;
                ram_waddr   = head_q;
                ram_wdata   = q_entry_i.word[StoreW-1:0];
                head_d      = ptr_inc(head_q);
                cnt_d       = cnt_q + CntW'(1);
                out_valid_d = 1'b1;
              end
              cdp_pkg::CmdPopFront: begin
                head_d    = ptr_dec(head_q);
                ram_raddr = ptr_dec(head_q);
                cnt_d     = cnt_q - CntW'(1);
                state_d   = StRead;
              end
              cdp_pkg::CmdPushBack: begin
                ram_we      = 1'b1;
                ram_waddr   = ptr_dec(tail_q);
                ram_wdata   = q_entry_i.word[StoreW-1:0];
                tail_d      = ptr_dec(tail_q);
                cnt_d       = cnt_q + CntW'(1);
                out_valid_d = 1'b1;
              end
              cdp_pkg::CmdPopBack: begin
                ram_raddr = tail_q;
                tail_d    = ptr_inc(tail_q);
                cnt_d     = cnt_q - CntW'(1);
                state_d   = StRead;
              end
              default: begin
                out_valid_d = 1'b1;
              end
            endcase
          end
        end
      end
      StRead: begin
        out_valid_d  = 1'b1;
        out_word_d   = cdp_pkg::WordBits'(ram_rdata);
        out_status_d = ent_status_q;
        out_count_d  = ent_count_q;
        state_d      = StIdle;
      end
      StRemCap: begin
        rd_word_d = ram_rdata;
        state_d   = StMvRd;
      end
      StMvRd: begin
        if (moves_q == '0) begin
          out_valid_d  = 1'b1;
          out_status_d = ent_status_q;
          out_count_d  = ent_count_q;
          if (is_ins_q) begin
            ram_we     = 1'b1;
            head_d     = ptr_inc(head_q);
            out_word_d = '0;
          end else begin
            head_d     = ptr_dec(head_q);
            out_word_d = cdp_pkg::WordBits'(rd_word_q);
          end
          state_d = StIdle;
        end else begin
          ram_raddr = nb;
          nb_d      = nb;
          state_d   = StMvWr;
        end
      end
      StMvWr: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        cur_d     = nb_q;
        moves_d   = moves_q - CntW'(1);
        state_d   = StMvRd;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      tail_q      <= '0;
      head_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tail_q      <= tail_d;
      head_q      <= head_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    moves_q      <= moves_d;
    cur_q        <= cur_d;
    nb_q         <= nb_d;
    is_ins_q     <= is_ins_d;
    ent_word_q   <= ent_word_d;
    rd_word_q    <= rd_word_d;
    ent_status_q <= ent_status_d;
    ent_count_q  <= ent_count_d;
    out_word_q   <= out_word_d;
    out_status_q <= out_status_d;
    out_count_q  <= out_count_d;
  end

  assign out_valid_o = out_valid_q;
  assign word_out_o  = out_word_q;
  assign status_o    = out_status_q;
  assign count_o     = out_count_q;

endmodule

FILE: rtl/core/circular_deque_positional.sv
// ----------------------------------------------------------------------------
// circular_deque_positional: fixed-capacity circular deque with indexed access
// Get, insert and remove by logical index, push and pop at either end.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: in_valid_i / in_stall_o carry command_i, position_i and
//   word_in_i. An item is taken on a rising edge with valid high, stall low.
//   Result channel: out_valid_o / out_stall_i carry word_out_o, status_o and
//   count_o, exactly one result item for every command item, in order.
// Timing:
//   The front end classifies each command in the cycle it is taken and drops
//   it into a two-entry queue, so in_stall_o rises only when that queue is full.
//   The back end owns the entry RAM (one write and one registered read port):
//     push, or any failed command : result (and push write) set from idle
//     get, pop                     : RAM read, then StRead takes the word
//     insert at index p            : count - p shifts, then the new word
//     remove at index p            : read, StRemCap, then count - 1 - p shifts
//   Each shifted entry takes one read (StMvRd) and one write (StMvWr).
//   While the back end is busy, an accepted command waits in the queue.
// Reset: the deque comes up empty; stored words need no clearing since only
//   written entries are ever read.
// Stall: a stalled result holds in the output register; the back end waits,
//   the queue fills, and then in_stall_o holds off new commands.
// ----------------------------------------------------------------------------
module circular_deque_positional #(
  parameter int unsigned DEPTH     = cdp_pkg::DefDepth,
  parameter int unsigned WORD_BITS = cdp_pkg::DefWordBits
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [cdp_pkg::CmdBits-1:0]    command_i,
  input  logic [cdp_pkg::PosBits-1:0]    position_i,
  input  logic [cdp_pkg::WordBits-1:0]   word_in_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [cdp_pkg::WordBits-1:0]   word_out_o,
  output logic [cdp_pkg::StatBits-1:0]   status_o,
  output logic [cdp_pkg::CountBits-1:0]  count_o
);

  cdp_pkg::entry_t front_entry, back_entry;
  logic            q_full, q_valid, q_pop, accept;

  // Take an item whenever the queue has room.
  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  // Classify: status and resulting count are known at acceptance.
  cdp_front #(
    .DEPTH (DEPTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .command_i  (command_i),
    .position_i (position_i),
    .word_in_i  (word_in_i),
    .entry_o    (front_entry)
  );

  // Buffer classified commands between the two halves.
  cdp_cmdq u_cmdq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (in_valid_i),
    .push_entry_i (front_entry),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .valid_o      (q_valid),
    .pop_entry_o  (back_entry)
  );

  // Execute on the RAM and hold the result until the receiver takes it.
  cdp_back #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_entry_i   (back_entry),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .word_out_o  (word_out_o),
    .status_o    (status_o),
    .count_o     (count_o)
  );

endmodule
